### sv/sprite_quad_vertex_setup_core_assert.svh
// Assertion macros used by the sprite vertex setup checker.
`ifndef SPRITE_QUAD_VERTEX_SETUP_CORE_ASSERT_SVH
`define SPRITE_QUAD_VERTEX_SETUP_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SQVS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SQVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sqvs_pkg.sv
// Types, constants and helper functions of the sprite vertex setup block.
`timescale 1ns / 1ps
`default_nettype none
package sqvs_pkg;

  localparam int ANGLE_TABLE_DEPTH = 1024;
  localparam int ANG_IDX_W = $clog2(ANGLE_TABLE_DEPTH);
  // Phase keeps only the bits that select a table entry
  localparam logic [15:0] PHASE_MASK =
    16'((32'hFFFF >> (16 - ANG_IDX_W)) << (16 - ANG_IDX_W));

  localparam int CFG_W       = 14;
  localparam int CFG_AW      = 4;
  localparam int NUM_W       = 36;
  localparam int NP_W        = 38;
  localparam int REM_W       = 36;
  localparam int DEN_W       = 18;
  localparam int DD_W        = 19;
  localparam int QUO_W       = 16;
  localparam int STEP_STAGES = 8;
  localparam int DIV_LAT     = STEP_STAGES + 1;

  localparam logic [CFG_W-1:0] VP_W_RST  = 14'd1280;
  localparam logic [CFG_W-1:0] VP_H_RST  = 14'd720;
  localparam logic [CFG_W-1:0] TEX_W_RST = 14'd256;
  localparam logic [CFG_W-1:0] TEX_H_RST = 14'd256;

  localparam logic [2:0] LAST_SLOT = 3'd5;

  typedef enum logic [1:0] {
    REG_VP_W,
    REG_VP_H,
    REG_TEX_W,
    REG_TEX_H
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] width;
    logic signed [15:0] height;
    logic [31:0]        color;
    logic [15:0]        angle;
    logic signed [15:0] src_left;
    logic signed [15:0] src_top;
    logic signed [15:0] src_width;
    logic signed [15:0] src_height;
  } req_t;

  typedef struct packed {
    req_t       req;
    logic [1:0] corner;
    logic       last;
  } job_t;

  typedef struct packed {
    logic [31:0] color;
    logic        last;
  } meta_t;

  // Two triangles: corners 0,1,2 then 2,1,3
  function automatic logic [1:0] corner_of(input logic [2:0] slot);
    logic [1:0] c;
    unique case (slot)
      3'd0: c = 2'd0;
      3'd1: c = 2'd1;
      3'd2: c = 2'd2;
      3'd3: c = 2'd2;
      3'd4: c = 2'd1;
      default: c = 2'd3;
    endcase
    return c;
  endfunction

  // Zero register acts as one
  function automatic logic [CFG_W-1:0] divisor(input logic [CFG_W-1:0] r);
    return (r == '0) ? CFG_W'(1) : r;
  endfunction

endpackage
`default_nettype wire

### sv/sqvs_if.sv
// Request and vertex channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface sqvs_req_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left;
  logic signed [15:0] top;
  logic signed [15:0] width;
  logic signed [15:0] height;
  logic [31:0]        color;
  logic [15:0]        angle;
  logic signed [15:0] src_left;
  logic signed [15:0] src_top;
  logic signed [15:0] src_width;
  logic signed [15:0] src_height;

  modport source (output valid, left, top, width, height, color, angle,
                  src_left, src_top, src_width, src_height, input ready);
  modport sink (input valid, left, top, width, height, color, angle,
                src_left, src_top, src_width, src_height, output ready);
endinterface

interface sqvs_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [31:0]        vertex_color;
  logic signed [15:0] tex_u;
  logic signed [15:0] tex_v;
  logic               last_vertex;

  modport source (output valid, pos_x, pos_y, vertex_color, tex_u, tex_v,
                  last_vertex, input ready);
  modport sink (input valid, pos_x, pos_y, vertex_color, tex_u, tex_v,
                last_vertex, output ready);
endinterface
`default_nettype wire

### sv/sprite_quad_vertex_setup_core.sv
// Sprite vertex setup top level: APB registers, sequencer, geometry, dividers.
// The six vertices of a request follow one vertex per cycle while the output
// is not stalled, set by the corner sequencer issuing one vertex job per
// cycle into the pipeline; it takes the next request as the last vertex job
// of the current one issues, so requests can follow back to back.
// Reset (synchronous, active low) empties the pipeline and loads the
// registers with 1280, 720, 256 and 256.
`timescale 1ns / 1ps
`default_nettype none
module sprite_quad_vertex_setup_core
  import sqvs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  sqvs_req_if.sink          in_req,
  sqvs_vtx_if.source        out_vtx,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [CFG_W-1:0] vp_w_r, vp_h_r, tex_w_r, tex_h_r;
  reg_idx_t         cfg_idx;
  logic             cfg_wr;

  logic adv;
  job_t job;
  logic job_v;

  logic [DEN_W-1:0]        w16, h16, tw, th;
  logic signed [NUM_W-1:0] xn, yn, un, vn;
  meta_t                   g_meta;
  logic                    g_v;
  logic signed [15:0]      qx, qy, qu, qv;

  meta_t dm_r [DIV_LAT];
  logic  dv_r [DIV_LAT];

  logic               out_v_r;
  logic signed [15:0] pos_x_r, pos_y_r, tex_u_r, tex_v_r;
  logic [31:0]        color_r;
  logic               last_r;

  // Configuration registers
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_w_r  <= VP_W_RST;
      vp_h_r  <= VP_H_RST;
      tex_w_r <= TEX_W_RST;
      tex_h_r <= TEX_H_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_VP_W:  vp_w_r  <= cfg_pwdata[CFG_W-1:0];
        REG_VP_H:  vp_h_r  <= cfg_pwdata[CFG_W-1:0];
        REG_TEX_W: tex_w_r <= cfg_pwdata[CFG_W-1:0];
        REG_TEX_H: tex_h_r <= cfg_pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_VP_W:  cfg_prdata = 32'(vp_w_r);
      REG_VP_H:  cfg_prdata = 32'(vp_h_r);
      REG_TEX_W: cfg_prdata = 32'(tex_w_r);
      REG_TEX_H: cfg_prdata = 32'(tex_h_r);
    endcase
  end

  assign w16 = {divisor(vp_w_r), 4'b0};
  assign h16 = {divisor(vp_h_r), 4'b0};
  assign tw  = DEN_W'(divisor(tex_w_r));
  assign th  = DEN_W'(divisor(tex_h_r));

  // Whole pipeline advances unless a finished vertex is held
  assign adv = !out_v_r || out_vtx.ready;

  sqvs_seq u_seq (
    .clk(clk), .rst_n(rst_n), .en(adv), .req(in_req), .job(job), .job_v(job_v)
  );

  sqvs_geom u_geom (
    .clk(clk), .rst_n(rst_n), .en(adv), .job(job), .job_v(job_v),
    .w16(w16), .h16(h16), .xn(xn), .yn(yn), .un(un), .vn(vn),
    .meta(g_meta), .out_v(g_v)
  );

  sqvs_div u_div_x (.clk(clk), .en(adv), .num(xn), .den(w16), .res(qx));
  sqvs_div u_div_y (.clk(clk), .en(adv), .num(yn), .den(h16), .res(qy));
  sqvs_div u_div_u (.clk(clk), .en(adv), .num(un), .den(tw),  .res(qu));
  sqvs_div u_div_v (.clk(clk), .en(adv), .num(vn), .den(th),  .res(qv));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dv_r[i] <= 1'b0;
      end
      out_v_r <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= g_v;
      for (int i = 1; i < DIV_LAT; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
      out_v_r <= dv_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dm_r[0] <= g_meta;
      for (int i = 1; i < DIV_LAT; i++) begin
        dm_r[i] <= dm_r[i-1];
      end
      pos_x_r <= qx;
      pos_y_r <= qy;
      tex_u_r <= qu;
      tex_v_r <= qv;
      color_r <= dm_r[DIV_LAT-1].color;
      last_r  <= dm_r[DIV_LAT-1].last;
    end
  end

  assign out_vtx.valid        = out_v_r;
  assign out_vtx.pos_x        = pos_x_r;
  assign out_vtx.pos_y        = pos_y_r;
  assign out_vtx.vertex_color = color_r;
  assign out_vtx.tex_u        = tex_u_r;
  assign out_vtx.tex_v        = tex_v_r;
  assign out_vtx.last_vertex  = last_r;

endmodule
`default_nettype wire

### sv/sqvs_seq.sv
// Corner sequencer: holds one request and issues its six vertex jobs.
`timescale 1ns / 1ps
`default_nettype none
module sqvs_seq
  import sqvs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  sqvs_req_if.sink   req,
  output job_t       job,
  output logic       job_v
);

  logic       busy_r, busy_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  req_t       spr_r;
  job_t       job_r;
  logic       job_v_r;
  logic       take;

  // Take a request when idle, or the next one while the last vertex of this one issues
  assign req.ready = !busy_r || (en && (cnt_r == LAST_SLOT));
  assign take      = req.valid && req.ready;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (take) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (en && busy_r) begin
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == LAST_SLOT) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      job_v_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      if (en) begin
        job_v_r <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      spr_r <= '{left: req.left, top: req.top, width: req.width,
                 height: req.height, color: req.color, angle: req.angle,
                 src_left: req.src_left, src_top: req.src_top,
                 src_width: req.src_width, src_height: req.src_height};
    end
    if (en) begin
      job_r <= '{req: spr_r, corner: corner_of(cnt_r), last: (cnt_r == LAST_SLOT)};
    end
  end

  assign job   = job_r;
  assign job_v = job_v_r;

endmodule
`default_nettype wire

### sv/sqvs_sincos.sv
// Four-stage quarter-wave polynomial sine of a binary angle, Q1.14 result.
`timescale 1ns / 1ps
`default_nettype none
module sqvs_sincos
  import sqvs_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        phase,
  output logic signed [15:0] val
);

  logic [15:0] z0, zz;
  logic [31:0] m1;
  logic [28:0] m2;
  logic [31:0] m3;
  logic [32:0] m4;
  logic [16:0] s4;
  logic [14:0] r4;

  logic [15:0] z1_r, z2_r, z2b_r, z3_r, t2_r;
  logic [15:0] sq1_r;
  logic [16:0] t4_r;
  logic        n1_r, n2_r, n3_r;
  logic signed [15:0] val_r;

  // Fold the phase onto the first quarter
  assign z0 = {1'b0, phase[13:0], 1'b0};
  assign zz = phase[14] ? (16'd32768 - z0) : z0;
  assign m1 = 32'(zz) * 32'(zz);
  assign m2 = 29'(sq1_r) * 29'(4640);
  assign m3 = 32'(t2_r) * 32'(z2b_r);
  assign m4 = 33'(t4_r) * 33'(z3_r);
  assign s4 = 17'(m4 >> 15);
  assign r4 = 15'((s4 + 17'd2) >> 2);

  always_ff @(posedge clk) begin
    if (en) begin
      z1_r  <= zz;
      n1_r  <= phase[15];
      sq1_r <= 16'(m1 >> 15);

      z2_r  <= z1_r;
      n2_r  <= n1_r;
      z2b_r <= sq1_r;
      t2_r  <= 16'd42047 - 16'(m2 >> 15);

      z3_r  <= z2_r;
      n3_r  <= n2_r;
      t4_r  <= 17'd102944 - 17'(m3 >> 15);

      if (r4 > 15'd16384) begin
        val_r <= n3_r ? -16'sd16384 : 16'sd16384;
      end else begin
        val_r <= n3_r ? -$signed(16'(r4)) : $signed(16'(r4));
      end
    end
  end

  assign val = val_r;

endmodule
`default_nettype wire

### sv/sqvs_geom.sv
// Corner geometry: rotation about the centre and division numerators.
`timescale 1ns / 1ps
`default_nettype none
module sqvs_geom
  import sqvs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  job_t                    job,
  input  logic                    job_v,
  input  logic [DEN_W-1:0]        w16,
  input  logic [DEN_W-1:0]        h16,
  output logic signed [NUM_W-1:0] xn,
  output logic signed [NUM_W-1:0] yn,
  output logic signed [NUM_W-1:0] un,
  output logic signed [NUM_W-1:0] vn,
  output meta_t                   meta,
  output logic                    out_v
);

  typedef struct packed {
    logic signed [17:0] cx;
    logic signed [17:0] cy;
    logic signed [16:0] ox;
    logic signed [16:0] oy;
    logic signed [16:0] un;
    logic signed [16:0] vn;
    meta_t              meta;
  } carry_t;

  carry_t carry_nxt;
  carry_t c_r [4];
  logic   v_r [7];

  logic [15:0]        ph;
  logic signed [15:0] sn, cs;

  logic signed [32:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [32:0] p1_nxt, p2_nxt, p3_nxt, p4_nxt;
  logic signed [17:0] cx5_r, cy5_r;
  logic signed [16:0] un5_r, vn5_r, un6_r, vn6_r;
  meta_t              m5_r, m6_r, m7_r;
  logic signed [34:0] x6_r, y6_r;
  logic signed [NUM_W-1:0] xn_r, yn_r, un_r, vn_r;

  assign ph = job.req.angle & PHASE_MASK;

  sqvs_sincos u_sin (.clk(clk), .en(en), .phase(ph), .val(sn));
  sqvs_sincos u_cos (.clk(clk), .en(en), .phase(ph + 16'h4000), .val(cs));

  // Centre in Q.1, half extents in Q.1 equal to the full size
  always_comb begin
    carry_nxt.cx = (18'(job.req.left) <<< 1) + 18'(job.req.width);
    carry_nxt.cy = (18'(job.req.top) <<< 1) + 18'(job.req.height);
    carry_nxt.ox = job.corner[0] ? 17'(job.req.width) : -17'(job.req.width);
    carry_nxt.oy = job.corner[1] ? 17'(job.req.height) : -17'(job.req.height);
    carry_nxt.un = job.corner[0] ? (17'(job.req.src_left) + 17'(job.req.src_width))
                                 : 17'(job.req.src_left);
    carry_nxt.vn = job.corner[1] ? (17'(job.req.src_top) + 17'(job.req.src_height))
                                 : 17'(job.req.src_top);
    carry_nxt.meta = '{color: job.req.color, last: job.last};
  end

  assign p1_nxt = cs * c_r[3].ox;
  assign p2_nxt = sn * c_r[3].oy;
  assign p3_nxt = sn * c_r[3].ox;
  assign p4_nxt = cs * c_r[3].oy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= job_v;
      for (int i = 1; i < 7; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0] <= carry_nxt;
      for (int i = 1; i < 4; i++) begin
        c_r[i] <= c_r[i-1];
      end

      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      p3_r  <= p3_nxt;
      p4_r  <= p4_nxt;
      cx5_r <= c_r[3].cx;
      cy5_r <= c_r[3].cy;
      un5_r <= c_r[3].un;
      vn5_r <= c_r[3].vn;
      m5_r  <= c_r[3].meta;

      x6_r  <= (35'(cx5_r) <<< 14) + 35'(p1_r) - 35'(p2_r);
      y6_r  <= (35'(cy5_r) <<< 14) + 35'(p3_r) + 35'(p4_r);
      un6_r <= un5_r;
      vn6_r <= vn5_r;
      m6_r  <= m5_r;

      xn_r <= 36'(x6_r) - $signed(36'({w16, 14'b0}));
      yn_r <= $signed(36'({h16, 14'b0})) - 36'(y6_r);
      un_r <= 36'(un6_r) <<< 10;
      vn_r <= 36'(vn6_r) <<< 10;
      m7_r <= m6_r;
    end
  end

  assign xn    = xn_r;
  assign yn    = yn_r;
  assign un    = un_r;
  assign vn    = vn_r;
  assign meta  = m7_r;
  assign out_v = v_r[6];

endmodule
`default_nettype wire

### sv/sqvs_div.sv
// Pipelined rounding divider with 16-bit saturated signed quotient.
`timescale 1ns / 1ps
`default_nettype none
module sqvs_div
  import sqvs_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic signed [QUO_W-1:0] res
);

  localparam int STEPS_PER = QUO_W / STEP_STAGES;

  logic signed [NP_W-1:0] num_ext, np_nxt, np_r;
  logic [NP_W-1:0]        bias;
  logic [DD_W-1:0]        dd0_r;

  logic [REM_W-1:0] rem_i [STEP_STAGES];
  logic [QUO_W-1:0] q_i   [STEP_STAGES];
  logic [DD_W-1:0]  dd_i  [STEP_STAGES];
  logic             lo_i  [STEP_STAGES];
  logic             hi_i  [STEP_STAGES];

  logic [REM_W-1:0] rem_r [STEP_STAGES];
  logic [QUO_W-1:0] q_r   [STEP_STAGES];
  logic [DD_W-1:0]  dd_r  [STEP_STAGES];
  logic             lo_r  [STEP_STAGES];
  logic             hi_r  [STEP_STAGES];

  // floor((2n+d)/2d) offset by 32768 quotients so that it stays unsigned
  assign num_ext = NP_W'(num);
  assign bias    = (NP_W'(den) << 16) + NP_W'(den);
  assign np_nxt  = (num_ext <<< 1) + $signed(bias);

  always_ff @(posedge clk) begin
    if (en) begin
      np_r  <= np_nxt;
      dd0_r <= {den, 1'b0};
    end
  end

  for (genvar g = 0; g < STEP_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign rem_i[g] = REM_W'(np_r);
      assign q_i[g]   = '0;
      assign dd_i[g]  = dd0_r;
      assign lo_i[g]  = np_r[NP_W-1];
      assign hi_i[g]  = !np_r[NP_W-1] && ($unsigned(np_r) >= NP_W'({dd0_r, 16'b0}));
    end else begin : g_next
      assign rem_i[g] = rem_r[g-1];
      assign q_i[g]   = q_r[g-1];
      assign dd_i[g]  = dd_r[g-1];
      assign lo_i[g]  = lo_r[g-1];
      assign hi_i[g]  = hi_r[g-1];
    end

    logic [REM_W-1:0] rem_nxt;
    logic [QUO_W-1:0] q_nxt;

    always_comb begin
      logic [REM_W-1:0] trial;
      rem_nxt = rem_i[g];
      q_nxt   = q_i[g];
      trial   = '0;
      for (int b = 0; b < STEPS_PER; b++) begin
        trial = REM_W'(dd_i[g]) << (QUO_W - 1 - STEPS_PER * g - b);
        if (rem_nxt >= trial) begin
          rem_nxt = rem_nxt - trial;
          q_nxt[QUO_W - 1 - STEPS_PER * g - b] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        q_r[g]   <= q_nxt;
        dd_r[g]  <= dd_i[g];
        lo_r[g]  <= lo_i[g];
        hi_r[g]  <= hi_i[g];
      end
    end
  end

  // Saturate out-of-range quotients, else undo the offset by flipping the top quotient bit
  always_comb begin
    priority if (lo_r[STEP_STAGES-1]) begin
      res = {1'b1, {(QUO_W-1){1'b0}}};
    end else if (hi_r[STEP_STAGES-1]) begin
      res = {1'b0, {(QUO_W-1){1'b1}}};
    end else begin
      res = {~q_r[STEP_STAGES-1][QUO_W-1], q_r[STEP_STAGES-1][QUO_W-2:0]};
    end
  end

endmodule
`default_nettype wire

### sv/sqvs_chk.sv
// Port-level checker for the sprite vertex setup core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_quad_vertex_setup_core_assert.svh"
module sqvs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] pos_x,
  input logic [15:0] pos_y,
  input logic        last_vertex,
  input logic        cfg_pready
);

  `SQVS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "vertex dropped while stalled")
  `SQVS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(pos_x) && $stable(pos_y) && $stable(last_vertex), "vertex changed while stalled")
  `SQVS_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "request taken before previous one issued")
  `SQVS_ASSERT_NOW(a_pready, 1'b1, cfg_pready, "register port not ready")

endmodule

bind sprite_quad_vertex_setup_core sqvs_chk u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_req.valid), .in_ready(in_req.ready),
  .out_valid(out_vtx.valid), .out_ready(out_vtx.ready),
  .pos_x(out_vtx.pos_x), .pos_y(out_vtx.pos_y),
  .last_vertex(out_vtx.last_vertex), .cfg_pready(cfg_pready)
);
`default_nettype wire

### bench/sprite_quad_vertex_setup_core_tb.sv
// Self-checking bench for the sprite vertex setup core: random requests, APB setup, vertex check.
`timescale 1ns / 1ps
`default_nettype none
module sprite_quad_vertex_setup_core_tb
  import sqvs_pkg::*;
();

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        vertex_color;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic               last_vertex;
  } vertex_t;

  class sprite_vertex_board;
    logic [CFG_W-1:0] vp_w, vp_h, tex_w, tex_h;
    vertex_t          pending[$];
    int               errors;

    function void clear_regs();
      vp_w = VP_W_RST; vp_h = VP_H_RST; tex_w = TEX_W_RST; tex_h = TEX_H_RST;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_VP_W:  vp_w  = value[CFG_W-1:0];
        REG_VP_H:  vp_h  = value[CFG_W-1:0];
        REG_TEX_W: tex_w = value[CFG_W-1:0];
        REG_TEX_H: tex_h = value[CFG_W-1:0];
      endcase
    endfunction

    function longint nonzero(logic [CFG_W-1:0] r);
      return (r == 0) ? 1 : longint'(r);
    endfunction

    // round half up
    function longint div_round(longint n, longint d);
      longint nn, dd, q;
      nn = 2 * n + d;
      dd = 2 * d;
      q = nn / dd;
      if ((nn % dd) != 0 && nn < 0) q -= 1;
      return q;
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint quarter_sine(longint z);
      longint z2, t, s;
      z2 = (z * z) >> 15;
      t = (4640 * z2) >> 15;
      t = 42047 - t;
      t = (t * z2) >> 15;
      t = 102944 - t;
      s = (t * z) >> 15;
      s = (s + 2) >> 2;
      if (s > 16384) s = 16384;
      return s;
    endfunction

    function longint table_sine(longint p);
      longint ph, q, z;
      ph = p & 16'hFFFF;
      q = ph >> 14;
      z = (ph & 14'h3FFF) << 1;
      case (q)
        0: return quarter_sine(z);
        1: return quarter_sine(32768 - z);
        2: return -quarter_sine(z);
        default: return -quarter_sine(32768 - z);
      endcase
    endfunction

    // Work out the six vertices of an accepted request
    function void note_request(req_t r);
      longint dx, dy, dw, dh, sx, sy, sw, sh, idx, ph, sn, cs, cx, cy;
      longint w16, h16, tw, th, ox, oy, bx, by, u0, u1, v0, v1;
      longint px[4], py[4];
      int k;
      vertex_t v;
      dx = longint'(r.left);  dy = longint'(r.top);
      dw = longint'(r.width); dh = longint'(r.height);
      sx = longint'(r.src_left);  sy = longint'(r.src_top);
      sw = longint'(r.src_width); sh = longint'(r.src_height);
      idx = (longint'(r.angle) * ANGLE_TABLE_DEPTH) >> 16;
      ph = (idx * 65536) / ANGLE_TABLE_DEPTH;
      sn = table_sine(ph);
      cs = table_sine(ph + 16384);
      cx = (2 * dx + dw) * 16384;
      cy = (2 * dy + dh) * 16384;
      w16 = 16 * nonzero(vp_w);
      h16 = 16 * nonzero(vp_h);
      tw = nonzero(tex_w);
      th = nonzero(tex_h);
      for (int c = 0; c < 4; c++) begin
        ox = c[0] ? dw : -dw;
        oy = c[1] ? dh : -dh;
        bx = cx + cs * ox - sn * oy;
        by = cy + sn * ox + cs * oy;
        px[c] = clip16(div_round(bx - 16384 * w16, w16));
        py[c] = clip16(div_round(16384 * h16 - by, h16));
      end
      u0 = clip16(div_round(sx * 1024, tw));
      u1 = clip16(div_round((sx + sw) * 1024, tw));
      v0 = clip16(div_round(sy * 1024, th));
      v1 = clip16(div_round((sy + sh) * 1024, th));
      for (int n = 0; n < 6; n++) begin
        k = (n == 0) ? 0 : (n == 1 || n == 4) ? 1 : (n == 5) ? 3 : 2;
        v.pos_x        = px[k][15:0];
        v.pos_y        = py[k][15:0];
        v.vertex_color = r.color;
        v.tex_u        = k[0] ? u1[15:0] : u0[15:0];
        v.tex_v        = k[1] ? v1[15:0] : v0[15:0];
        v.last_vertex  = (n == 5);
        pending = {pending, v};
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t exp_v;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected vertex %p", got);
        return;
      end
      exp_v = pending.pop_front();
      if (got !== exp_v) begin
        errors++;
        if (errors <= 10) $display("vertex mismatch: expected %p got %p", exp_v, got);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;
  longint            cycles = 0;
  bit                drain_fast = 1'b0;

  sqvs_req_if req_if ();
  sqvs_vtx_if vtx_if ();

  sprite_vertex_board board = new();

  sprite_quad_vertex_setup_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_if.sink),
    .out_vtx     (vtx_if.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("sprite_quad_vertex_setup_core_tb NOT OK");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Vertex stalls, with stretches of no stall
  initial begin
    int n;
    vtx_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      vtx_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      n = drain_fast ? 0 : gap_len();
      if (n > 0) begin
        vtx_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    vertex_t got;
    if (rst_n && vtx_if.valid && vtx_if.ready) begin
      got.pos_x        = vtx_if.pos_x;
      got.pos_y        = vtx_if.pos_y;
      got.vertex_color = vtx_if.vertex_color;
      got.tex_u        = vtx_if.tex_u;
      got.tex_v        = vtx_if.tex_v;
      got.last_vertex  = vtx_if.last_vertex;
      board.check_vertex(got);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(4 * int'(idx));
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.write_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Hold until every vertex is back and the pipeline has emptied
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] vw, logic [31:0] vh, logic [31:0] tw,
                          logic [31:0] th);
    write_reg(REG_VP_W, vw);
    write_reg(REG_VP_H, vh);
    write_reg(REG_TEX_W, tw);
    write_reg(REG_TEX_H, th);
  endtask

  task automatic send_request(req_t r);
    int n;
    req_if.valid      <= 1'b1;
    req_if.left       <= r.left;
    req_if.top        <= r.top;
    req_if.width      <= r.width;
    req_if.height     <= r.height;
    req_if.color      <= r.color;
    req_if.angle      <= r.angle;
    req_if.src_left   <= r.src_left;
    req_if.src_top    <= r.src_top;
    req_if.src_width  <= r.src_width;
    req_if.src_height <= r.src_height;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    board.note_request(r);
    n = gap_len();
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic req_t random_request();
    req_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    // Mostly on-screen sprites so results stay off the saturation rails
    if ($urandom_range(0, 2) != 0) begin
      r.left       = 16'($urandom_range(0, 20000)) - 16'sd2000;
      r.top        = 16'($urandom_range(0, 12000)) - 16'sd1000;
      r.width      = 16'($urandom_range(0, 4000)) - 16'sd1000;
      r.height     = 16'($urandom_range(0, 4000)) - 16'sd1000;
      r.src_left   = 16'($urandom_range(0, 4096));
      r.src_top    = 16'($urandom_range(0, 4096));
      r.src_width  = 16'($urandom_range(0, 2048)) - 16'sd512;
      r.src_height = 16'($urandom_range(0, 2048)) - 16'sd512;
    end
    return r;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_request(random_request());
  endtask

  initial begin
    req_t r;
    int   angles[8];
    angles = '{0, 16384, 32768, 49152, 65535, 63, 64, 8192};
    board.clear_regs();
    req_if.valid      = 1'b0;
    req_if.left       = '0;
    req_if.top        = '0;
    req_if.width      = '0;
    req_if.height     = '0;
    req_if.color      = '0;
    req_if.angle      = '0;
    req_if.src_left   = '0;
    req_if.src_top    = '0;
    req_if.src_width  = '0;
    req_if.src_height = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: every quadrant of the angle
    foreach (angles[i]) begin
      r = '{left: 16'sd1600, top: 16'sd800, width: 16'sd640, height: 16'sd320,
            color: 32'h11223344, angle: angles[i][15:0], src_left: 16'sd0,
            src_top: 16'sd0, src_width: 16'sd256, src_height: 16'sd512};
      send_request(r);
    end
    // Field extremes, mirrored sizes, saturation
    r = '{left: 16'h8000, top: 16'h8000, width: 16'h8000, height: 16'h8000,
          color: 32'h0, angle: 16'h0, src_left: 16'h8000, src_top: 16'h8000,
          src_width: 16'h8000, src_height: 16'h8000};
    send_request(r);
    r = '{left: 16'h7FFF, top: 16'h7FFF, width: 16'h7FFF, height: 16'h7FFF,
          color: 32'hFFFFFFFF, angle: 16'hFFFF, src_left: 16'h7FFF,
          src_top: 16'h7FFF, src_width: 16'h7FFF, src_height: 16'h7FFF};
    send_request(r);
    r = '{left: 16'sd3200, top: 16'sd2400, width: -16'sd640, height: -16'sd320,
          color: 32'hA5A55A5A, angle: 16'h4000, src_left: 16'sd1024,
          src_top: 16'sd512, src_width: -16'sd256, src_height: -16'sd512};
    send_request(r);
    wait_idle();

    // Zero divisors act as one: most results rail
    set_regs(32'h0, 32'h0, 32'h0, 32'h0);
    r.angle = 16'h2000;
    send_request(r);
    run_random(8);
    wait_idle();

    // Largest in-range and above-range divisors, high bits masked off
    set_regs(32'd8192, 32'hFFFF_3FFF, 32'd16383, 32'd8192);
    run_random(40);
    wait_idle();

    set_regs(32'd1, 32'd1, 32'd1, 32'd1);
    run_random(30);
    wait_idle();

    set_regs(32'd640, 32'd480, 32'd64, 32'd128);
    run_random(80);
    wait_idle();

    set_regs(32'd1920, 32'd1080, 32'd4096, 32'd1024);
    drain_fast = 1'b1;
    run_random(40);
    drain_fast = 1'b0;
    run_random(60);
    wait_idle();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("sprite_quad_vertex_setup_core_tb OK");
    end else begin
      $display("sprite_quad_vertex_setup_core_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+sv
sv/sqvs_pkg.sv
sv/sqvs_if.sv
sv/sqvs_seq.sv
sv/sqvs_sincos.sv
sv/sqvs_geom.sv
sv/sqvs_div.sv
sv/sprite_quad_vertex_setup_core.sv
sv/sqvs_chk.sv
bench/sprite_quad_vertex_setup_core_tb.sv
